// File: hw/rtl/sfcp_pkg.sv
// ============================================================================
// sfcp_pkg
// Shared types and constants for the stuffed frame command parser: byte
// codes, token classes passed from the front end to the back end, and
// event kinds.
// ============================================================================
package sfcp_pkg;

    // framing byte codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // command codes
    localparam logic [7:0] CMD_SWITCH  = 8'h00;
    localparam logic [7:0] CMD_MESSAGE = 8'h01;

    // switch value reserved as the none marker
    localparam logic [15:0] SWITCH_NONE = 16'hFFFF;

    // default depth of the token queue
    localparam int QUEUE_DEPTH = 4;

    // event kinds on the result channel
    typedef enum logic [2:0] {
        EV_SWITCH    = 3'd0,
        EV_TOPIC_LEN = 3'd1,
        EV_TOPIC     = 3'd2,
        EV_PAY_LEN   = 3'd3,
        EV_PAYLOAD   = 3'd4
    } t_event_kind;

    // class of an unescaped data byte, as seen by the front end
    typedef enum logic [2:0] {
        TK_SW_HI     = 3'd0,
        TK_SW_LO     = 3'd1,
        TK_TOPIC_LEN = 3'd2,
        TK_TOPIC     = 3'd3,
        TK_PAY_HI    = 3'd4,
        TK_PAY_LO    = 3'd5,
        TK_PAYLOAD   = 3'd6
    } t_tok_cls;

    // one classified word between front and back
    typedef struct packed {
        t_tok_cls   cls;
        logic [7:0] data;
        logic       last;
    } t_token;

endpackage

// File: hw/rtl/sfcp_front.sv
// ============================================================================
// sfcp_front
// Front end: hunts for the frame flag, removes escapes, tracks the command
// phase and byte counts, and classifies each data byte after the command into a token.
// ============================================================================
module sfcp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_raw_byte,
    input  logic                i_full,
    output logic                o_push,
    output sfcp_pkg::t_token    o_token
);

    typedef enum logic [9:0] {
        PH_HUNT      = 10'b00_0000_0001,
        PH_CMD       = 10'b00_0000_0010,
        PH_SW_HI     = 10'b00_0000_0100,
        PH_SW_LO     = 10'b00_0000_1000,
        PH_TOPIC_LEN = 10'b00_0001_0000,
        PH_TOPIC     = 10'b00_0010_0000,
        PH_PAY_HI    = 10'b00_0100_0000,
        PH_PAY_LO    = 10'b00_1000_0000,
        PH_PAYLOAD   = 10'b01_0000_0000,
        PH_END       = 10'b10_0000_0000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_rem, n_rem;
    logic [7:0]  r_held, n_held;

    logic        accept;
    logic [7:0]  data;
    logic [15:0] rem_dec;
    logic [15:0] pay_len;

    assign accept  = i_valid && !i_full;
    assign data    = r_esc ? (i_raw_byte ^ sfcp_pkg::ESC_XOR) : i_raw_byte;
    assign rem_dec = r_rem - 16'd1;
    assign pay_len = {r_held, data};

    // phase update and token classification
    always_comb begin
        n_phase      = r_phase;
        n_esc        = r_esc;
        n_rem        = r_rem;
        n_held       = r_held;
        o_push       = 1'b0;
        o_token.cls  = sfcp_pkg::TK_PAYLOAD;
        o_token.data = data;
        o_token.last = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_END: begin
                    // raw end byte, taken whatever its value
                    n_phase = PH_HUNT;
                    n_esc   = 1'b0;
                end
                PH_CMD, PH_SW_HI, PH_SW_LO, PH_TOPIC_LEN, PH_TOPIC,
                PH_PAY_HI, PH_PAY_LO, PH_PAYLOAD: begin
                    if (!r_esc && i_raw_byte == sfcp_pkg::ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc = 1'b0;
                        unique case (r_phase)
                            PH_CMD: begin
                                priority if (data == sfcp_pkg::CMD_SWITCH) begin
                                    n_phase = PH_SW_HI;
                                end else if (data == sfcp_pkg::CMD_MESSAGE) begin
                                    n_phase = PH_TOPIC_LEN;
                                end else begin
                                    n_phase = PH_END;
                                end
                            end
                            PH_SW_HI: begin
                                n_phase     = PH_SW_LO;
                                o_push      = 1'b1;
                                o_token.cls = sfcp_pkg::TK_SW_HI;
                            end
                            PH_SW_LO: begin
                                n_phase      = PH_END;
                                o_push       = 1'b1;
                                o_token.cls  = sfcp_pkg::TK_SW_LO;
                                o_token.last = 1'b1;
                            end
                            PH_TOPIC_LEN: begin
                                n_rem       = {8'd0, data};
                                n_phase     = (data == 8'd0) ? PH_PAY_HI : PH_TOPIC;
                                o_push      = 1'b1;
                                o_token.cls = sfcp_pkg::TK_TOPIC_LEN;
                            end
                            PH_TOPIC: begin
                                n_rem       = rem_dec;
                                n_phase     = (rem_dec == 16'd0) ? PH_PAY_HI : PH_TOPIC;
                                o_push      = 1'b1;
                                o_token.cls = sfcp_pkg::TK_TOPIC;
                            end
                            PH_PAY_HI: begin
                                n_held      = data;
                                n_phase     = PH_PAY_LO;
                                o_push      = 1'b1;
                                o_token.cls = sfcp_pkg::TK_PAY_HI;
                            end
                            PH_PAY_LO: begin
                                n_rem        = pay_len;
                                n_phase      = (pay_len == 16'd0) ? PH_END : PH_PAYLOAD;
                                o_push       = 1'b1;
                                o_token.cls  = sfcp_pkg::TK_PAY_LO;
                                o_token.last = (pay_len == 16'd0);
                            end
                            default: begin
                                // payload byte
                                n_rem        = rem_dec;
                                n_phase      = (rem_dec == 16'd0) ? PH_END : PH_PAYLOAD;
                                o_push       = 1'b1;
                                o_token.cls  = sfcp_pkg::TK_PAYLOAD;
                                o_token.last = (rem_dec == 16'd0);
                            end
                        endcase
                    end
                end
                default: begin
                    // hunting, and any stray code
                    n_phase = (i_raw_byte == sfcp_pkg::FLAG_BYTE) ? PH_CMD : PH_HUNT;
                    n_esc   = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
        end
    end

    // counters and held byte
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_held <= n_held;
    end

endmodule

// File: hw/rtl/sfcp_queue.sv
// ============================================================================
// sfcp_queue
// Short token queue between front and back end, so each side can stall on
// its own.
// ============================================================================
module sfcp_queue #(
    parameter int DEPTH = sfcp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfcp_pkg::t_token    i_token,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output sfcp_pkg::t_token    o_token
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfcp_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");
    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");
`endif

endmodule

// File: hw/rtl/sfcp_back.sv
// ============================================================================
// sfcp_back
// Back end: turns tokens into events, joins high and low bytes of 16-bit
// fields, drops the reserved switch number, and holds the result register.
// ============================================================================
module sfcp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  sfcp_pkg::t_token    i_q_token,
    output logic                o_pop,
    output logic                o_valid,
    output logic [2:0]          o_event_kind,
    output logic [15:0]         o_event_value,
    output logic                o_message_last,
    input  logic                i_stall
);

    logic        r_valid;
    logic [2:0]  r_kind;
    logic [15:0] r_value;
    logic        r_last;
    logic [7:0]  r_high;

    logic        free;
    logic        emit;
    logic [2:0]  n_kind;
    logic [15:0] n_value;
    logic [15:0] joined;

    assign free   = !r_valid || !i_stall;
    assign o_pop  = i_q_valid && free;
    assign joined = {r_high, i_q_token.data};

    // event decode
    always_comb begin
        emit    = 1'b1;
        n_kind  = sfcp_pkg::EV_PAYLOAD;
        n_value = {8'd0, i_q_token.data};
        unique case (i_q_token.cls)
            sfcp_pkg::TK_SW_HI, sfcp_pkg::TK_PAY_HI: begin
                emit = 1'b0;
            end
            sfcp_pkg::TK_SW_LO: begin
                n_kind  = sfcp_pkg::EV_SWITCH;
                n_value = joined;
                emit    = (joined != sfcp_pkg::SWITCH_NONE);
            end
            sfcp_pkg::TK_TOPIC_LEN: begin
                n_kind = sfcp_pkg::EV_TOPIC_LEN;
            end
            sfcp_pkg::TK_TOPIC: begin
                n_kind = sfcp_pkg::EV_TOPIC;
            end
            sfcp_pkg::TK_PAY_LO: begin
                n_kind  = sfcp_pkg::EV_PAY_LEN;
                n_value = joined;
            end
            default: begin
                n_kind = sfcp_pkg::EV_PAYLOAD;
            end
        endcase
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= o_pop && emit;
        end
    end

    // result payload and held high byte
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_last  <= i_q_token.last;
        end
        if (o_pop && (i_q_token.cls == sfcp_pkg::TK_SW_HI ||
                      i_q_token.cls == sfcp_pkg::TK_PAY_HI)) begin
            r_high <= i_q_token.data;
        end
    end

    assign o_valid        = r_valid;
    assign o_event_kind   = r_kind;
    assign o_event_value  = r_value;
    assign o_message_last = r_last;

`ifndef NO_ASSERTIONS
    a_no_none_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == sfcp_pkg::EV_SWITCH) |->
        (r_value != sfcp_pkg::SWITCH_NONE && r_last))
        else $error("reserved switch number reported");
    a_topic_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == sfcp_pkg::EV_TOPIC_LEN || r_kind == sfcp_pkg::EV_TOPIC))
        |-> !r_last)
        else $error("topic event marked last");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !o_pop)
        else $error("queue popped while result is stalled");
`endif

endmodule

// File: hw/rtl/stuffed_frame_command_parser.sv
// ============================================================================
// stuffed_frame_command_parser
// Byte-stuffed frame deframer and command parser: front end, token queue,
// back end with result register.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_raw_byte
//   result    o_valid   i_stall   o_event_kind, o_event_value, o_message_last
//
// Takes one raw byte per cycle, sustained, while the token queue has room.
// After its byte is accepted, a result passes through the token queue and then
// the result register before it is valid and can be taken.
// o_stall rises only when the token queue is full, which happens only while
// the result side stalls; the back end keeps draining whenever it can.
// Reset is synchronous and active low.
// ============================================================================
module stuffed_frame_command_parser #(
    parameter int QUEUE_DEPTH = sfcp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_raw_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_event_value,
    output logic        o_message_last,
    input  logic        i_stall
);

    logic             push, full, q_valid, pop;
    sfcp_pkg::t_token push_token, q_token;

    assign o_stall = full;

    // deframing and classification
    sfcp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_raw_byte (i_raw_byte),
        .i_full     (full),
        .o_push     (push),
        .o_token    (push_token)
    );

    // token queue
    sfcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_token),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    // event assembly and result register
    sfcp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_token      (q_token),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_event_value  (o_event_value),
        .o_message_last (o_message_last),
        .i_stall        (i_stall)
    );

endmodule

// File: sim/sfcp_checker.sv
// ============================================================================
// sfcp_checker
// Watches both channels of the stuffed frame command parser. Each raw word
// taken on the input side runs through a local deframer and command decoder.
// Every event taken on the result side is compared field by field with the
// oldest predicted event. Counts mismatches and events seen for the top.
// ============================================================================
module sfcp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_kind,
    input  logic [15:0] i_event_value,
    input  logic        i_message_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_event_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder position within a frame
    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_CMD     = 4'd1,
        ST_SW_HI   = 4'd2,
        ST_SW_LO   = 4'd3,
        ST_TLEN    = 4'd4,
        ST_TOPIC   = 4'd5,
        ST_PLEN_HI = 4'd6,
        ST_PLEN_LO = 4'd7,
        ST_PAYLOAD = 4'd8,
        ST_END     = 4'd9
    } t_frame_pos;

    typedef struct {
        sfcp_pkg::t_event_kind kind;
        logic [15:0]           value;
        logic                  last;
    } t_parsed_event;

    t_frame_pos    frame_pos;
    logic          esc_armed;
    logic [15:0]   count_left;
    logic [7:0]    high_byte;
    t_parsed_event pending_events[$];

    // one line per mismatch
    task report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task add_event(input sfcp_pkg::t_event_kind kind, input logic [15:0] value,
                   input logic last);
        t_parsed_event ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = last;
        pending_events.push_back(ev);
    endtask

    // advance the local decoder by one raw word
    task decode_word(input logic [7:0] raw);
        logic [7:0]  d;
        logic [15:0] v;
        if (frame_pos == ST_END) begin
            // end word taken raw, whatever it holds
            frame_pos = ST_HUNT;
            esc_armed = 1'b0;
        end else if (frame_pos < ST_CMD || frame_pos > ST_PAYLOAD) begin
            frame_pos = (raw == sfcp_pkg::FLAG_BYTE) ? ST_CMD : ST_HUNT;
            esc_armed = 1'b0;
        end else if (!esc_armed && raw == sfcp_pkg::ESC_BYTE) begin
            esc_armed = 1'b1;
        end else begin
            d = esc_armed ? (raw ^ sfcp_pkg::ESC_XOR) : raw;
            esc_armed = 1'b0;
            case (frame_pos)
                ST_CMD: begin
                    if (d == sfcp_pkg::CMD_SWITCH)
                        frame_pos = ST_SW_HI;
                    else if (d == sfcp_pkg::CMD_MESSAGE)
                        frame_pos = ST_TLEN;
                    else
                        frame_pos = ST_END;
                end
                ST_SW_HI: begin
                    high_byte = d;
                    frame_pos = ST_SW_LO;
                end
                ST_SW_LO: begin
                    v = {high_byte, d};
                    frame_pos = ST_END;
                    // the none marker never shows up as a request
                    if (v != sfcp_pkg::SWITCH_NONE)
                        add_event(sfcp_pkg::EV_SWITCH, v, 1'b1);
                end
                ST_TLEN: begin
                    count_left = {8'h00, d};
                    frame_pos = (d == 8'h00) ? ST_PLEN_HI : ST_TOPIC;
                    add_event(sfcp_pkg::EV_TOPIC_LEN, {8'h00, d}, 1'b0);
                end
                ST_TOPIC: begin
                    count_left = count_left - 16'd1;
                    if (count_left == 16'd0)
                        frame_pos = ST_PLEN_HI;
                    add_event(sfcp_pkg::EV_TOPIC, {8'h00, d}, 1'b0);
                end
                ST_PLEN_HI: begin
                    high_byte = d;
                    frame_pos = ST_PLEN_LO;
                end
                ST_PLEN_LO: begin
                    v = {high_byte, d};
                    count_left = v;
                    if (v == 16'd0) begin
                        frame_pos = ST_END;
                        add_event(sfcp_pkg::EV_PAY_LEN, v, 1'b1);
                    end else begin
                        frame_pos = ST_PAYLOAD;
                        add_event(sfcp_pkg::EV_PAY_LEN, v, 1'b0);
                    end
                end
                default: begin
                    count_left = count_left - 16'd1;
                    if (count_left == 16'd0) begin
                        frame_pos = ST_END;
                        add_event(sfcp_pkg::EV_PAYLOAD, {8'h00, d}, 1'b1);
                    end else begin
                        add_event(sfcp_pkg::EV_PAYLOAD, {8'h00, d}, 1'b0);
                    end
                end
            endcase
        end
    endtask

    // sample both channels at the edge where words move
    always @(posedge i_clk) begin
        t_parsed_event want;
        if (!i_rst_n) begin
            frame_pos = ST_HUNT;
            esc_armed = 1'b0;
            count_left = 16'd0;
            high_byte = 8'h00;
            pending_events.delete();
            o_fail_count = 0;
            o_event_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_events.size() == 0) begin
                    report_mismatch("event with nothing pending, value", i_event_value, 16'd0);
                end else begin
                    want = pending_events.pop_front();
                    if (i_event_kind !== want.kind)
                        report_mismatch("event_kind", {13'd0, i_event_kind},
                                        {13'd0, want.kind});
                    if (i_event_value !== want.value)
                        report_mismatch("event_value", i_event_value, want.value);
                    if (i_message_last !== want.last)
                        report_mismatch("message_last", {15'd0, i_message_last},
                                        {15'd0, want.last});
                end
                o_event_count++;
            end
            if (i_in_valid && !i_in_stall)
                decode_word(i_raw_byte);
        end
        o_pending = pending_events.size();
    end

endmodule

// File: sim/tb_stuffed_frame_command_parser.sv
// ============================================================================
// tb_stuffed_frame_command_parser
// Feeds raw serial words to the stuffed frame command parser: a few hand-made
// frames first, then random stuffed frames with random content, mixed with
// line noise and unknown commands. Both sides idle at random. The checker
// beside the block predicts and compares; this module gives the verdict.
// ============================================================================
module tb_stuffed_frame_command_parser;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_raw_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_event_kind;
    logic [15:0] o_event_value;
    logic        o_message_last;

    int fail_count;
    int pending_count;
    int event_count;

    logic [7:0] line_q[$];
    int words_sent = 0;
    int frames_built = 5;
    int switch_frames = 2;
    int message_frames = 2;
    int tx_mode = 0;
    int tx_left = 0;
    int rx_mode = 0;
    int rx_left = 0;

    // hand-made frames: switch, none marker, unknown command with a raw
    // escape as its end word, escaped command with empty topic and payload,
    // escaped flag in a topic and a raw flag in a payload
    localparam logic [7:0] HAND_LINE [30] = '{
        8'h55, sfcp_pkg::FLAG_BYTE, sfcp_pkg::CMD_SWITCH, 8'h12, 8'h34,
        sfcp_pkg::FLAG_BYTE,
        sfcp_pkg::FLAG_BYTE, sfcp_pkg::CMD_SWITCH, 8'hFF, 8'hFF, 8'h00,
        sfcp_pkg::FLAG_BYTE, 8'hAA, sfcp_pkg::ESC_BYTE,
        sfcp_pkg::FLAG_BYTE, sfcp_pkg::ESC_BYTE, 8'h21, 8'h00, 8'h00, 8'h00,
        sfcp_pkg::FLAG_BYTE,
        sfcp_pkg::FLAG_BYTE, sfcp_pkg::CMD_MESSAGE, 8'h01, sfcp_pkg::ESC_BYTE,
        8'h5E, 8'h00, 8'h01, sfcp_pkg::FLAG_BYTE,
        8'hFF
    };

    stuffed_frame_command_parser i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_raw_byte     (i_raw_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_event_kind   (o_event_kind),
        .o_event_value  (o_event_value),
        .o_message_last (o_message_last),
        .i_stall        (i_stall)
    );

    sfcp_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_raw_byte     (i_raw_byte),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_event_kind   (o_event_kind),
        .i_event_value  (o_event_value),
        .i_message_last (o_message_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_event_count  (event_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // idle length per word; the mode holds for a stretch so that calm
    // stretches, short gaps and long gaps all occur
    function automatic int pick_wait(inout int mode, inout int left);
        if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // data word with stuffing; escape must be escaped, others sometimes are
    task automatic push_data(input logic [7:0] d);
        if (d == sfcp_pkg::ESC_BYTE ||
            (d == sfcp_pkg::FLAG_BYTE && $urandom_range(0, 1) == 1) ||
            $urandom_range(0, 9) == 0) begin
            line_q.push_back(sfcp_pkg::ESC_BYTE);
            line_q.push_back(d ^ sfcp_pkg::ESC_XOR);
        end else begin
            line_q.push_back(d);
        end
    endtask

    // one random frame, preceded by a little line noise
    task automatic build_frame();
        int          sel;
        int          noise;
        int          tlen;
        int          plen;
        logic [7:0]  b;
        logic [15:0] sw;
        noise = $urandom_range(0, 2);
        for (int k = 0; k < noise; k++) begin
            b = 8'($urandom);
            line_q.push_back((b == sfcp_pkg::FLAG_BYTE) ? 8'h00 : b);
        end
        line_q.push_back(sfcp_pkg::FLAG_BYTE);
        sel = $urandom_range(0, 99);
        if (sel < 38) begin
            push_data(sfcp_pkg::CMD_SWITCH);
            case ($urandom_range(0, 9))
                0: sw = sfcp_pkg::SWITCH_NONE;
                1: sw = 16'h0000;
                2: sw = {sfcp_pkg::FLAG_BYTE, sfcp_pkg::ESC_BYTE};
                3: sw = 16'hFFFE;
                default: sw = 16'($urandom);
            endcase
            push_data(sw[15:8]);
            push_data(sw[7:0]);
            switch_frames++;
        end else if (sel < 88) begin
            push_data(sfcp_pkg::CMD_MESSAGE);
            tlen = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
            push_data(tlen[7:0]);
            for (int k = 0; k < tlen; k++)
                push_data(8'($urandom));
            plen = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 320) :
                                                  $urandom_range(0, 8);
            push_data(plen[15:8]);
            push_data(plen[7:0]);
            for (int k = 0; k < plen; k++)
                push_data(8'($urandom));
            message_frames++;
        end else if (sel < 96) begin
            // unknown command, possibly stuffed
            push_data(8'($urandom_range(2, 255)));
        end else begin
            // back-to-back flags: the second is an unknown command
            line_q.push_back(sfcp_pkg::FLAG_BYTE);
        end
        // end word is raw and may be anything
        line_q.push_back(($urandom_range(0, 1) == 1) ? sfcp_pkg::FLAG_BYTE : 8'($urandom));
        frames_built++;
    endtask

    // offer one word and hold it until taken
    task automatic send_word(input logic [7:0] b);
        int   w;
        logic taken;
        w = pick_wait(tx_mode, tx_left);
        if (w > 0) begin
            i_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_byte <= b;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        words_sent++;
    endtask

    task automatic flush_line();
        while (line_q.size() > 0)
            send_word(line_q.pop_front());
    endtask

    // result side: stall a random number of cycles before each event
    initial begin
        int   w;
        logic got;
        wait (i_rst_n);
        forever begin
            w = pick_wait(rx_mode, rx_left);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                got = o_valid;
                @(posedge i_clk);
            end while (!got);
        end
    end

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (HAND_LINE[k])
            line_q.push_back(HAND_LINE[k]);
        flush_line();
        while (words_sent < 480) begin
            build_frame();
            flush_line();
        end
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (8) @(posedge i_clk);
        $display("%0d raw words in %0d frames (%0d switch, %0d message, rest unknown)",
                 words_sent, frames_built, switch_frames, message_frames);
        $display("%0d events compared", event_count);
        if (fail_count == 0) begin
            $display("tb_stuffed_frame_command_parser: clean");
        end else begin
            $display("tb_stuffed_frame_command_parser: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout with %0d events still pending", pending_count);
        $display("tb_stuffed_frame_command_parser: errors");
        $finish;
    end

endmodule
